[hdl/homogeneous_2d_transform_unit_macros.svh]
// Assertion macros for the homogeneous 2D transform unit.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef HOMOGENEOUS_2D_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_2D_TRANSFORM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define H2T_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("h2t: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define H2T_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("h2t: next-cycle check failed");

`endif

[hdl/h2t_pkg.sv]
// Shared types, widths and codes for the homogeneous 2D transform unit.
// No dependencies; every module of the block imports this package.
package h2t_pkg;

    localparam int unsigned FRAC_BITS_DEFAULT = 16;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned NUM_TERMS = 7;
    localparam int unsigned NUM_PROD  = 3;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned SUM_W     = PROD_W + 2;
    localparam int unsigned TDATA_W   = NUM_TERMS * DATA_W;
    localparam int unsigned CFG_IDX_W = 3;

    // Term order, which is also the packing order on tdata.
    localparam int unsigned T_XX = 0;
    localparam int unsigned T_XY = 1;
    localparam int unsigned T_YX = 2;
    localparam int unsigned T_YY = 3;
    localparam int unsigned T_U  = 4;
    localparam int unsigned T_V  = 5;
    localparam int unsigned T_S  = 6;

    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic
    {
        OP_POINT   = 1'b0,
        OP_COMPOSE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ROT_XX      = 3'd0,
        REG_ROT_XY      = 3'd1,
        REG_ROT_YX      = 3'd2,
        REG_ROT_YY      = 3'd3,
        REG_ORIGIN_U    = 3'd4,
        REG_ORIGIN_V    = 3'd5,
        REG_FRAME_SCALE = 3'd6
    } cfg_reg_t;

    // Coefficients after the degenerate-rotation and zero-scale rules.
    typedef struct packed
    {
        logic signed [DATA_W-1:0] ts;
        logic signed [DATA_W-1:0] tv;
        logic signed [DATA_W-1:0] tu;
        logic signed [DATA_W-1:0] ayy;
        logic signed [DATA_W-1:0] ayx;
        logic signed [DATA_W-1:0] axy;
        logic signed [DATA_W-1:0] axx;
    } coef_t;

    // Input operand; b_xx lands in the lowest bits, matching s_tdata.
    typedef struct packed
    {
        logic signed [DATA_W-1:0] b_s;
        logic signed [DATA_W-1:0] b_v;
        logic signed [DATA_W-1:0] b_u;
        logic signed [DATA_W-1:0] b_yy;
        logic signed [DATA_W-1:0] b_yx;
        logic signed [DATA_W-1:0] b_xy;
        logic signed [DATA_W-1:0] b_xx;
    } pt_t;

    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        smul = PROD_W'(a) * PROD_W'(b);
    endfunction

endpackage

[hdl/homogeneous_2d_transform_unit.sv]
// Top level of the homogeneous 2D transform unit: streams, configuration
// and the four-stage pipeline. Depends on h2t_pkg, h2t_cfg, h2t_mul, h2t_acc.
//
//  channel   handshake            payload
//  s_*       s_tvalid/s_tready    s_tdata: b_xx..b_s, s_tuser: operation
//  m_*       m_tvalid/m_tready    m_tdata: o_xx..o_s, m_tuser: saturated
//  cfg_*     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle while m_tready stays high. The stages, in order: input
// register, multiplier array, three-operand adders, shift and saturate.
// Reset clears the stage valid bits and loads the configuration defaults.
// A low m_tready holds the output register; empty stages ahead keep filling,
// and s_tready falls only when all four stages hold an item.
module homogeneous_2d_transform_unit #(
    parameter int unsigned FRAC_BITS = h2t_pkg::FRAC_BITS_DEFAULT
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // b_xx, b_xy, b_yx, b_yy, b_u, b_v, b_s (32 bits each)
    input  logic [h2t_pkg::TDATA_W-1:0]     s_tdata,
    // operation
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // o_xx, o_xy, o_yx, o_yy, o_u, o_v, o_s (32 bits each)
    output logic [h2t_pkg::TDATA_W-1:0]     m_tdata,
    // saturated
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [h2t_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [h2t_pkg::DATA_W-1:0]      cfg_data
);
    import h2t_pkg::*;

    coef_t                    coef;
    logic                     mul_valid;
    logic                     acc_ready;
    logic signed [PROD_W-1:0] prod [NUM_TERMS][NUM_PROD];
    logic signed [DATA_W-1:0] res  [NUM_TERMS];

    h2t_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    h2t_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_pt     (pt_t'(s_tdata)),
        .coef      (coef),
        .out_valid (mul_valid),
        .out_ready (acc_ready),
        .prod      (prod)
    );

    h2t_acc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (acc_ready),
        .prod      (prod),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res),
        .sat       (m_tuser)
    );

    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            m_tdata[t*DATA_W +: DATA_W] = res[t];
        end
    end

endmodule

[hdl/h2t_cfg.sv]
// Configuration registers and the rules that turn them into coefficients.
// Depends on h2t_pkg.
module h2t_cfg #(
    parameter int unsigned FRAC_BITS = h2t_pkg::FRAC_BITS_DEFAULT
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [h2t_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [h2t_pkg::DATA_W-1:0]      cfg_data,
    output h2t_pkg::coef_t                  coef
);
    import h2t_pkg::*;

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] rot_xx_reg;
    logic signed [DATA_W-1:0] rot_xy_reg;
    logic signed [DATA_W-1:0] rot_yx_reg;
    logic signed [DATA_W-1:0] rot_yy_reg;
    logic signed [DATA_W-1:0] origin_u_reg;
    logic signed [DATA_W-1:0] origin_v_reg;
    logic signed [DATA_W-1:0] frame_scale_reg;
    logic                     degenerate;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_xx_reg      <= ONE;
            rot_xy_reg      <= '0;
            rot_yx_reg      <= '0;
            rot_yy_reg      <= ONE;
            origin_u_reg    <= '0;
            origin_v_reg    <= '0;
            frame_scale_reg <= ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROT_XX:      rot_xx_reg      <= cfg_data;
                REG_ROT_XY:      rot_xy_reg      <= cfg_data;
                REG_ROT_YX:      rot_yx_reg      <= cfg_data;
                REG_ROT_YY:      rot_yy_reg      <= cfg_data;
                REG_ORIGIN_U:    origin_u_reg    <= cfg_data;
                REG_ORIGIN_V:    origin_v_reg    <= cfg_data;
                REG_FRAME_SCALE: frame_scale_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A rotation with a zero first column or a zero bottom row falls back to
    // unit diagonal terms; the off-diagonal terms stay as written.
    assign degenerate = ((rot_xx_reg == '0) && (rot_yx_reg == '0)) ||
                        ((rot_yx_reg == '0) && (rot_yy_reg == '0));

    always_comb
    begin
        coef.axx = degenerate ? ONE : rot_xx_reg;
        coef.axy = rot_xy_reg;
        coef.ayx = rot_yx_reg;
        coef.ayy = degenerate ? ONE : rot_yy_reg;
        coef.tu  = origin_u_reg;
        coef.tv  = origin_v_reg;
        coef.ts  = (frame_scale_reg == '0) ? ONE : frame_scale_reg;
    end

endmodule

[hdl/h2t_mul.sv]
// Input register stage and the product stage of the transform pipeline.
// Depends on h2t_pkg.
module h2t_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  h2t_pkg::op_t                       in_op,
    input  h2t_pkg::pt_t                       in_pt,
    input  h2t_pkg::coef_t                     coef,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [h2t_pkg::PROD_W-1:0]  prod [h2t_pkg::NUM_TERMS][h2t_pkg::NUM_PROD]
);
    import h2t_pkg::*;

    logic                     va_reg;
    logic                     va_next;
    op_t                      op_a_reg;
    pt_t                      pt_a_reg;
    logic                     vb_reg;
    logic                     vb_next;
    logic                     en_a;
    logic                     en_b;
    logic signed [PROD_W-1:0] prod_next [NUM_TERMS][NUM_PROD];
    logic signed [PROD_W-1:0] prod_reg  [NUM_TERMS][NUM_PROD];

    // A stage takes new contents when it is empty or its contents move on.
    assign en_b     = !vb_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;
    assign va_next  = en_a ? in_valid : va_reg;
    assign vb_next  = en_b ? va_reg : vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && in_valid)
        begin
            op_a_reg <= in_op;
            pt_a_reg <= in_pt;
        end
    end

    // Rotation terms stay zero for a point, so they cannot clip there.
    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            for (int k = 0; k < NUM_PROD; k++)
            begin
                prod_next[t][k] = '0;
            end
        end
        if (op_a_reg == OP_COMPOSE)
        begin
            prod_next[T_XX][0] = smul(coef.axx, pt_a_reg.b_xx);
            prod_next[T_XX][1] = smul(coef.axy, pt_a_reg.b_yx);
            prod_next[T_XY][0] = smul(coef.axx, pt_a_reg.b_xy);
            prod_next[T_XY][1] = smul(coef.axy, pt_a_reg.b_yy);
            prod_next[T_YX][0] = smul(coef.ayx, pt_a_reg.b_xx);
            prod_next[T_YX][1] = smul(coef.ayy, pt_a_reg.b_yx);
            prod_next[T_YY][0] = smul(coef.ayx, pt_a_reg.b_xy);
            prod_next[T_YY][1] = smul(coef.ayy, pt_a_reg.b_yy);
        end
        prod_next[T_U][0] = smul(coef.axx, pt_a_reg.b_u);
        prod_next[T_U][1] = smul(coef.axy, pt_a_reg.b_v);
        prod_next[T_U][2] = smul(coef.tu,  pt_a_reg.b_s);
        prod_next[T_V][0] = smul(coef.ayx, pt_a_reg.b_u);
        prod_next[T_V][1] = smul(coef.ayy, pt_a_reg.b_v);
        prod_next[T_V][2] = smul(coef.tv,  pt_a_reg.b_s);
        prod_next[T_S][0] = smul(coef.ts,  pt_a_reg.b_s);
    end

    always_ff @(posedge clk)
    begin
        if (en_b && va_reg)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = vb_reg;
    assign prod      = prod_reg;

endmodule

[hdl/h2t_acc.sv]
// Sum stage and the shift and saturate output stage of the pipeline.
// Depends on h2t_pkg.
module h2t_acc #(
    parameter int unsigned FRAC_BITS = h2t_pkg::FRAC_BITS_DEFAULT
)(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [h2t_pkg::PROD_W-1:0]  prod [h2t_pkg::NUM_TERMS][h2t_pkg::NUM_PROD],
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [h2t_pkg::DATA_W-1:0]  res [h2t_pkg::NUM_TERMS],
    output logic                               sat
);
    import h2t_pkg::*;

    logic                     vc_reg;
    logic                     vc_next;
    logic                     vd_reg;
    logic                     vd_next;
    logic                     en_c;
    logic                     en_d;
    logic signed [SUM_W-1:0]  sum_next [NUM_TERMS];
    logic signed [SUM_W-1:0]  sum_reg  [NUM_TERMS];
    logic signed [SUM_W-1:0]  shifted  [NUM_TERMS];
    logic [NUM_TERMS-1:0]     clip;
    logic signed [DATA_W-1:0] res_next [NUM_TERMS];
    logic signed [DATA_W-1:0] res_reg  [NUM_TERMS];
    logic                     sat_reg;

    assign en_d     = !vd_reg || out_ready;
    assign en_c     = !vc_reg || en_d;
    assign in_ready = en_c;
    assign vc_next  = en_c ? in_valid : vc_reg;
    assign vd_next  = en_d ? vc_reg : vd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vc_next;
            vd_reg <= vd_next;
        end
    end

    // Three full products summed exactly; two guard bits cover the carry.
    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            sum_next[t] = SUM_W'(prod[t][0]) + SUM_W'(prod[t][1]) + SUM_W'(prod[t][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c && in_valid)
        begin
            sum_reg <= sum_next;
        end
    end

    // The arithmetic shift floors; the result fits when every bit from the
    // new sign position up agrees.
    always_comb
    begin
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            shifted[t] = sum_reg[t] >>> FRAC_BITS;
            clip[t]    = !((&shifted[t][SUM_W-1:DATA_W-1]) ||
                           !(|shifted[t][SUM_W-1:DATA_W-1]));
            if (clip[t])
            begin
                res_next[t] = shifted[t][SUM_W-1] ? SAT_NEG : SAT_POS;
            end
            else
            begin
                res_next[t] = shifted[t][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d && vc_reg)
        begin
            res_reg <= res_next;
            sat_reg <= |clip;
        end
    end

    assign out_valid = vd_reg;
    assign res       = res_reg;
    assign sat       = sat_reg;

endmodule

[hdl/h2t_checker.sv]
// Port-level checks for the homogeneous 2D transform unit, bound to the top.
// Depends on h2t_pkg and homogeneous_2d_transform_unit_macros.svh.
`include "homogeneous_2d_transform_unit_macros.svh"

module h2t_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [h2t_pkg::TDATA_W-1:0]     m_tdata,
    input  logic                            m_tuser
);
    import h2t_pkg::*;

    logic clip_seen;

    always_comb
    begin
        clip_seen = 1'b0;
        for (int t = 0; t < NUM_TERMS; t++)
        begin
            clip_seen = clip_seen ||
                        (m_tdata[t*DATA_W +: DATA_W] == SAT_POS) ||
                        (m_tdata[t*DATA_W +: DATA_W] == SAT_NEG);
        end
    end

    // A stalled result must stay put until it is taken.
    `H2T_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))

    // The input side can only back up once the output register is occupied.
    `H2T_ASSERT_SAME(a_ready_when_drained, !s_tready, m_tvalid)

    // A saturation flag always comes with at least one clipped field.
    `H2T_ASSERT_SAME(a_sat_has_clip, m_tvalid && m_tuser, clip_seen)

endmodule

bind homogeneous_2d_transform_unit h2t_checker u_h2t_checker (.*);

[verif/homogeneous_2d_transform_unit_tb.sv]
// Self-checking testbench for the homogeneous 2D transform unit.
// Drives point and compose transfers under random idling on both streams and
// checks every result against a local fixed-point predictor. Needs h2t_pkg.
`timescale 1ns / 1ps

module tb;

    import h2t_pkg::*;

    localparam int unsigned FRAC_BITS  = FRAC_BITS_DEFAULT;
    localparam int unsigned ACC_W      = 72;
    localparam int unsigned NUM_REGS   = 7;
    localparam int unsigned PIPE_SLACK = 12;

    // Index 7 has no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_TWO  = 32'h0002_0000;
    localparam logic [DATA_W-1:0] Q_M1   = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;

    localparam logic signed [ACC_W-1:0] TERM_HI = 72'sd2147483647;
    localparam logic signed [ACC_W-1:0] TERM_LO = -72'sd2147483648;

    typedef struct
    {
        op_t op;
        pt_t b;
    } xform_req_t;

    typedef struct packed
    {
        logic               sat;
        logic [TDATA_W-1:0] terms;
    } xform_res_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    logic signed [DATA_W-1:0] frame_regs [NUM_REGS];
    xform_req_t               pending_xforms [$];
    xform_res_t               predicted_frames [$];
    xform_req_t               in_flight;
    xform_res_t               want;
    int unsigned              send_gap = 0;
    int unsigned              stall_left = 0;
    bit                       no_idle = 1'b0;
    int                       mismatches = 0;

    homogeneous_2d_transform_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic signed [ACC_W-1:0] mul_wide(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [ACC_W-1:0] wa;
        logic signed [ACC_W-1:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // The shift floors toward minus infinity, then the term is clipped.
    function automatic logic [DATA_W-1:0] clip_term(
        input logic signed [ACC_W-1:0] acc,
        inout logic                     sat
    );
        logic signed [ACC_W-1:0] q;
        q = acc >>> FRAC_BITS;
        if (q > TERM_HI)
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (q < TERM_LO)
        begin
            sat = 1'b1;
            return Q_MIN;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic xform_res_t predict_frame(input xform_req_t req);
        logic signed [DATA_W-1:0] axx;
        logic signed [DATA_W-1:0] axy;
        logic signed [DATA_W-1:0] ayx;
        logic signed [DATA_W-1:0] ayy;
        logic signed [DATA_W-1:0] tu;
        logic signed [DATA_W-1:0] tv;
        logic signed [DATA_W-1:0] ts;
        logic                     sat;
        xform_res_t               res;
        axx = frame_regs[REG_ROT_XX];
        axy = frame_regs[REG_ROT_XY];
        ayx = frame_regs[REG_ROT_YX];
        ayy = frame_regs[REG_ROT_YY];
        tu  = frame_regs[REG_ORIGIN_U];
        tv  = frame_regs[REG_ORIGIN_V];
        ts  = frame_regs[REG_FRAME_SCALE];
        // A rotation with an empty first column or second row falls back to unit diagonal.
        if ((axx == 0 && ayx == 0) || (ayx == 0 && ayy == 0))
        begin
            axx = Q_ONE;
            ayy = Q_ONE;
        end
        if (ts == 0)
            ts = Q_ONE;
        sat = 1'b0;
        res.terms = '0;
        if (req.op == OP_COMPOSE)
        begin
            res.terms[T_XX*DATA_W +: DATA_W] =
                clip_term(mul_wide(axx, req.b.b_xx) + mul_wide(axy, req.b.b_yx), sat);
            res.terms[T_XY*DATA_W +: DATA_W] =
                clip_term(mul_wide(axx, req.b.b_xy) + mul_wide(axy, req.b.b_yy), sat);
            res.terms[T_YX*DATA_W +: DATA_W] =
                clip_term(mul_wide(ayx, req.b.b_xx) + mul_wide(ayy, req.b.b_yx), sat);
            res.terms[T_YY*DATA_W +: DATA_W] =
                clip_term(mul_wide(ayx, req.b.b_xy) + mul_wide(ayy, req.b.b_yy), sat);
        end
        res.terms[T_U*DATA_W +: DATA_W] = clip_term(mul_wide(axx, req.b.b_u)
            + mul_wide(axy, req.b.b_v) + mul_wide(tu, req.b.b_s), sat);
        res.terms[T_V*DATA_W +: DATA_W] = clip_term(mul_wide(ayx, req.b.b_u)
            + mul_wide(ayy, req.b.b_v) + mul_wide(tv, req.b.b_s), sat);
        res.terms[T_S*DATA_W +: DATA_W] = clip_term(mul_wide(ts, req.b.b_s), sat);
        res.sat = sat;
        return res;
    endfunction

    function automatic string term_name(input int unsigned k);
        case (k)
            T_XX:    return "o_xx";
            T_XY:    return "o_xy";
            T_YX:    return "o_yx";
            T_YY:    return "o_yy";
            T_U:     return "o_u";
            T_V:     return "o_v";
            default: return "o_s";
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // Mix of zeros, extremes, small Q16.16 values within +-4.0 and raw words.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return Q_MAX;
            2:       return Q_MIN;
            3, 4, 5: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    // Input stream: one item held until its transfer, then the next after a random gap that may be empty.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_frames.push_back(predict_frame(in_flight));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_xforms.size() != 0)
                begin
                    in_flight = pending_xforms.pop_front();
                    s_tdata  <= in_flight.b;
                    s_tuser  <= in_flight.op;
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output stream: compare each transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_frames.size() == 0)
                begin
                    $error("result transfer with nothing predicted");
                    mismatches++;
                end
                else
                begin
                    want = predicted_frames.pop_front();
                    for (int unsigned k = 0; k < NUM_TERMS; k++)
                    begin
                        if (m_tdata[k*DATA_W +: DATA_W] !== want.terms[k*DATA_W +: DATA_W])
                        begin
                            $error("%s expected %0d actual %0d", term_name(k),
                                   $signed(want.terms[k*DATA_W +: DATA_W]),
                                   $signed(m_tdata[k*DATA_W +: DATA_W]));
                            mismatches++;
                        end
                    end
                    if (m_tuser !== want.sat)
                    begin
                        $error("saturated expected %0d actual %0d", want.sat, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    task automatic push_item(
        input op_t         op,
        input logic [31:0] xx,
        input logic [31:0] xy,
        input logic [31:0] yx,
        input logic [31:0] yy,
        input logic [31:0] u,
        input logic [31:0] v,
        input logic [31:0] s
    );
        xform_req_t req;
        req.op     = op;
        req.b.b_xx = xx;
        req.b.b_xy = xy;
        req.b.b_yx = yx;
        req.b.b_yy = yy;
        req.b.b_u  = u;
        req.b.b_v  = v;
        req.b.b_s  = s;
        pending_xforms.push_back(req);
    endtask

    task automatic push_random();
        push_item(op_t'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
                  pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx != REG_SPARE)
            frame_regs[idx] = val;
    endtask

    task automatic set_frame(
        input logic [31:0] rxx,
        input logic [31:0] rxy,
        input logic [31:0] ryx,
        input logic [31:0] ryy,
        input logic [31:0] tu,
        input logic [31:0] tv,
        input logic [31:0] ts,
        input bit          touch_spare
    );
        write_reg(REG_ROT_XX, rxx);
        write_reg(REG_ROT_XY, rxy);
        write_reg(REG_ROT_YX, ryx);
        write_reg(REG_ROT_YY, ryy);
        write_reg(REG_ORIGIN_U, tu);
        write_reg(REG_ORIGIN_V, tv);
        write_reg(REG_FRAME_SCALE, ts);
        if (touch_spare)
            write_reg(REG_SPARE, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Waits for the streams to drain, then lets the pipeline go quiet.
    task automatic settle();
        while (pending_xforms.size() != 0 || s_tvalid || predicted_frames.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    initial
    begin
        frame_regs[REG_ROT_XX]      = Q_ONE;
        frame_regs[REG_ROT_XY]      = '0;
        frame_regs[REG_ROT_YX]      = '0;
        frame_regs[REG_ROT_YY]      = Q_ONE;
        frame_regs[REG_ORIGIN_U]    = '0;
        frame_regs[REG_ORIGIN_V]    = '0;
        frame_regs[REG_FRAME_SCALE] = Q_ONE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset frame: identity, so results are easy to reason about.
        push_item(OP_POINT, '0, '0, '0, '0, '0, '0, '0);
        push_item(OP_POINT, '0, '0, '0, '0, Q_ONE, Q_TWO, Q_ONE);
        push_item(OP_POINT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_item(OP_COMPOSE, Q_ONE, '0, '0, Q_ONE, 32'h0003_0000, Q_M1, Q_ONE);
        push_item(OP_COMPOSE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_item(OP_COMPOSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        settle();

        // Largest frame: sums overflow upward and downward, and the unused index is written.
        set_frame(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
        push_item(OP_POINT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        push_item(OP_COMPOSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_item(OP_POINT, '0, '0, '0, '0, 32'h1, '0, '0);
        settle();

        // Most negative frame, with a tiny negative point.
        set_frame(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        push_item(OP_COMPOSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        push_item(OP_POINT, '0, '0, '0, '0, 32'hFFFF_FFFF, '0, '0);
        settle();

        // Empty first column and zero scale.
        set_frame('0, Q_TWO, '0, 32'h0003_0000, Q_ONE, Q_M1, '0, 1'b0);
        push_item(OP_POINT, '0, '0, '0, '0, Q_ONE, Q_ONE, Q_ONE);
        push_item(OP_COMPOSE, Q_HALF, Q_M1, Q_TWO, Q_ONE, Q_ONE, Q_M1, Q_TWO);
        settle();

        // Empty second row, negative scale.
        set_frame(32'hFFFE_0000, Q_HALF, '0, '0, Q_TWO, Q_HALF, Q_M1, 1'b0);
        push_item(OP_POINT, '0, '0, '0, '0, Q_TWO, Q_M1, Q_ONE);
        push_item(OP_COMPOSE, Q_ONE, Q_HALF, Q_M1, Q_TWO, Q_HALF, Q_ONE, Q_M1);
        settle();

        // Quarter turn: zero diagonal but not degenerate.
        set_frame('0, Q_M1, Q_ONE, '0, Q_HALF, Q_TWO, Q_ONE, 1'b0);
        push_item(OP_POINT, '0, '0, '0, '0, Q_ONE, '0, Q_ONE);
        push_item(OP_COMPOSE, Q_ONE, Q_TWO, Q_M1, Q_HALF, Q_TWO, Q_ONE, Q_HALF);
        settle();

        for (int ph = 0; ph < 16; ph++)
        begin
            no_idle = (ph % 4 == 3);
            set_frame(pick_word(), pick_word(), pick_word(), pick_word(),
                      pick_word(), pick_word(), pick_word(), ph % 5 == 0);
            for (int n = 0; n < 105; n++)
                push_random();
            settle();
        end

        if (mismatches == 0)
            $display("homogeneous_2d_transform_unit: match");
        else
            $display("homogeneous_2d_transform_unit: mismatch");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("homogeneous_2d_transform_unit: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/h2t_pkg.sv
hdl/h2t_cfg.sv
hdl/h2t_mul.sv
hdl/h2t_acc.sv
hdl/homogeneous_2d_transform_unit.sv
hdl/h2t_checker.sv
verif/homogeneous_2d_transform_unit_tb.sv
